[rtl/photometric_stereo_normal_albedo_defines.svh]
// assertion macros for the photometric stereo normal and albedo block
`ifndef PHOTOMETRIC_STEREO_NORMAL_ALBEDO_DEFINES_SVH
`define PHOTOMETRIC_STEREO_NORMAL_ALBEDO_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PSNA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psna assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PSNA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psna assertion failed");

`endif

[rtl/psna_pkg.sv]
// constants and register codes of the photometric stereo normal and albedo block
`default_nettype none
package psna_pkg;
  localparam int unsigned MAX_LIGHTS_DEF = 6;
  localparam int unsigned NUM_OBS        = 6;
  localparam int unsigned OBS_W          = 16;
  localparam int unsigned COEF_W         = 20;
  localparam int unsigned COEFS_W        = 3 * COEF_W;
  localparam int unsigned PROD_W         = OBS_W + 1 + COEF_W;
  localparam int unsigned ACC_W          = 39;
  localparam int unsigned G_W            = 31;
  localparam int unsigned SQ_W           = 2 * G_W;
  localparam int unsigned ROOT_W         = 31;
  localparam int unsigned Q_W            = 15;
  localparam int unsigned NUM_W          = G_W + Q_W;
  localparam int unsigned DEN_W          = ROOT_W + 1;
  localparam int unsigned NORM_W         = 16;
  localparam int unsigned ALB_W          = 24;
  localparam int unsigned NL_W           = 3;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [NL_W-1:0]   NL_SIX   = 3'd6;
  localparam logic [NL_W-1:0]   NL_RESET = 3'd4;
  localparam logic [ALB_W-1:0]  THR_RESET = 24'd1;
  localparam logic [Q_W-1:0]    ONE_Q14  = 15'd16384;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LIGHTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT5     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd7;
endpackage
`default_nettype wire

[rtl/photometric_stereo_normal_albedo.sv]
// top level: pipelined lambertian photometric stereo, normal and albedo per pixel
//
// One pixel enters and one result leaves per clock unless the pipe holds. Its stages:
// one multiply stage (18 products obs times coefficient), one accumulate and round
// stage, one squaring stage, one sum-of-squares stage, 31 square root stages (one
// root bit each), one post stage (dark test, divider setup), 15 divide stages (one
// quotient bit each, three lanes) and the output register. The whole pipe advances
// together; it holds only while a result waits in the output register and out_stall
// is high, so in_stall follows that condition. The albedo is the integer root of the
// sum of squares shifted down by 8 bits, which shares the square root with the
// normal. Configuration writes are taken at any time and must only be made while
// the pipe is empty.
`default_nettype none
module photometric_stereo_normal_albedo #(
  parameter int unsigned MAX_LIGHTS = psna_pkg::MAX_LIGHTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [psna_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psna_pkg::COEFS_W-1:0]       cfg_wdata,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [psna_pkg::OBS_W-1:0]         in_obs_0,
  input  logic [psna_pkg::OBS_W-1:0]         in_obs_1,
  input  logic [psna_pkg::OBS_W-1:0]         in_obs_2,
  input  logic [psna_pkg::OBS_W-1:0]         in_obs_3,
  input  logic [psna_pkg::OBS_W-1:0]         in_obs_4,
  input  logic [psna_pkg::OBS_W-1:0]         in_obs_5,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [psna_pkg::NORM_W-1:0] out_normal_x,
  output logic signed [psna_pkg::NORM_W-1:0] out_normal_y,
  output logic signed [psna_pkg::NORM_W-1:0] out_normal_z,
  output logic [psna_pkg::ALB_W-1:0]         out_albedo,
  output logic                               out_dark_pixel
);
  import psna_pkg::*;

  `include "photometric_stereo_normal_albedo_defines.svh"

  // stage positions in the valid chain
  localparam int unsigned SQRT_STAGES = ROOT_W;
  localparam int unsigned DIV_STAGES  = Q_W;
  localparam int unsigned NST         = 4 + SQRT_STAGES + 1 + DIV_STAGES + 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [NL_W-1:0]    num_lights_r;
  logic [ALB_W-1:0]   thr_r;
  logic [COEFS_W-1:0] coef_r [0:MAX_LIGHTS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_lights_r <= NL_RESET;
      thr_r        <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_LIGHTS: num_lights_r <= cfg_wdata[NL_W-1:0];
        CFG_THRESHOLD:  thr_r        <= cfg_wdata[ALB_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficient rows, one register per light that the build provides
  for (genvar li = 0; li < MAX_LIGHTS; li++) begin : g_coef
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coef_r[li] <= '0;
      end else if (cfg_we && cfg_index == CFG_LIGHT0 + CFG_IDX_W'(li)) begin
        coef_r[li] <= cfg_wdata;
      end
    end
  end

  // six lights only when asked and when the build has them
  logic use6;
  assign use6 = (num_lights_r == NL_SIX) && (MAX_LIGHTS >= 6);

  // ---------------------------------------------------------------------------
  // pipeline control: all stages move together
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v_r;
  logic           adv;

  assign adv      = !(v_r[NST-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: products
  // ---------------------------------------------------------------------------
  logic [OBS_W-1:0]         obs [0:NUM_OBS-1];
  logic signed [PROD_W-1:0] prod_r [0:2][0:NUM_OBS-1];

  assign obs[0] = in_obs_0;
  assign obs[1] = in_obs_1;
  assign obs[2] = in_obs_2;
  assign obs[3] = in_obs_3;
  assign obs[4] = in_obs_4;
  assign obs[5] = in_obs_5;

  for (genvar li = 0; li < NUM_OBS; li++) begin : g_mul
    logic [COEFS_W-1:0] row;
    logic               used;
    if (li < MAX_LIGHTS) begin : g_have
      assign row = coef_r[li];
    end else begin : g_none
      assign row = '0;
    end
    // lights four and five drop out with four lights
    assign used = (li < 4) || use6;
    for (genvar ri = 0; ri < 3; ri++) begin : g_row
      logic signed [OBS_W:0]    o_s;
      logic signed [COEF_W-1:0] c_s;
      assign o_s = used ? $signed({1'b0, obs[li]}) : '0;
      assign c_s = $signed(row[ri*COEF_W +: COEF_W]);
      always_ff @(posedge clk) begin
        if (adv) begin
          prod_r[ri][li] <= o_s * c_s;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: accumulate, round half up to Q.16, split sign and magnitude
  // ---------------------------------------------------------------------------
  logic [G_W-1:0] ga_r [0:2];
  logic [2:0]     gs_r;

  for (genvar ri = 0; ri < 3; ri++) begin : g_acc
    logic signed [ACC_W-1:0] acc_nxt;
    logic signed [ACC_W-1:0] rnd;
    logic [G_W-1:0]          g;
    always_comb begin
      acc_nxt = '0;
      for (int li = 0; li < NUM_OBS; li++) begin
        acc_nxt = acc_nxt + ACC_W'(prod_r[ri][li]);
      end
    end
    assign rnd = acc_nxt + ACC_W'(128);
    assign g   = rnd[ACC_W-1:8];
    always_ff @(posedge clk) begin
      if (adv) begin
        gs_r[ri] <= g[G_W-1];
        ga_r[ri] <= g[G_W-1] ? (~g + G_W'(1)) : g;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: squares
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0] sqr_r [0:2];
  logic [G_W-1:0]  ga3_r [0:2];
  logic [2:0]      gs3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ri = 0; ri < 3; ri++) begin
        sqr_r[ri] <= ga_r[ri] * ga_r[ri];
        ga3_r[ri] <= ga_r[ri];
      end
      gs3_r <= gs_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4 and square root stages: index 0 holds the sum of squares
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0]   sq_rem_r  [0:SQRT_STAGES];
  logic [ROOT_W-1:0] sq_root_r [0:SQRT_STAGES];
  logic [G_W-1:0]    sq_ga_r   [0:SQRT_STAGES][0:2];
  logic [2:0]        sq_gs_r   [0:SQRT_STAGES];
  logic              sq_zero_r [0:SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem_r[0]  <= sqr_r[0] + sqr_r[1] + sqr_r[2];
      sq_root_r[0] <= '0;
      for (int ri = 0; ri < 3; ri++) begin
        sq_ga_r[0][ri] <= ga3_r[ri];
      end
      sq_gs_r[0]   <= gs3_r;
      sq_zero_r[0] <= (ga3_r[0] == '0) && (ga3_r[1] == '0) && (ga3_r[2] == '0);
    end
  end

  // one root bit per stage, most significant first
  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    localparam int unsigned P = SQRT_STAGES - 1 - j;
    logic [SQ_W:0]       trial;
    logic                fits;
    logic [SQ_W-1:0]     rem_nxt;
    logic [ROOT_W-1:0]   root_nxt;
    assign trial    = ((SQ_W+1)'(sq_root_r[j]) << (P + 1)) | ((SQ_W+1)'(1) << (2 * P));
    assign fits     = {1'b0, sq_rem_r[j]} >= trial;
    assign rem_nxt  = fits ? SQ_W'({1'b0, sq_rem_r[j]} - trial) : sq_rem_r[j];
    assign root_nxt = fits ? (sq_root_r[j] | (ROOT_W'(1) << P)) : sq_root_r[j];
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[j+1]  <= rem_nxt;
        sq_root_r[j+1] <= root_nxt;
        for (int ri = 0; ri < 3; ri++) begin
          sq_ga_r[j+1][ri] <= sq_ga_r[j][ri];
        end
        sq_gs_r[j+1]   <= sq_gs_r[j];
        sq_zero_r[j+1] <= sq_zero_r[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // post stage: albedo, dark test, divider operands
  // ---------------------------------------------------------------------------
  logic [ROOT_W-1:0] mag;
  logic [ALB_W-1:0]  alb_nxt;
  logic              dark_nxt;

  assign mag      = sq_root_r[SQRT_STAGES];
  // floor(sqrt(s >> 16)) equals the root shifted down by 8; it never saturates
  assign alb_nxt  = ALB_W'(mag[ROOT_W-1:8]);
  assign dark_nxt = sq_zero_r[SQRT_STAGES] || (alb_nxt < thr_r);

  logic [NUM_W-1:0] dv_rem_r  [0:DIV_STAGES][0:2];
  logic [Q_W-1:0]   dv_q_r    [0:DIV_STAGES][0:2];
  logic [DEN_W-1:0] dv_den_r  [0:DIV_STAGES];
  logic [2:0]       dv_gs_r   [0:DIV_STAGES];
  logic [ALB_W-1:0] dv_alb_r  [0:DIV_STAGES];
  logic             dv_dark_r [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ri = 0; ri < 3; ri++) begin
        // 2 * 16384 * |g| + mag, rounding half away from zero
        dv_rem_r[0][ri] <= {sq_ga_r[SQRT_STAGES][ri], Q_W'(0)} + NUM_W'(mag);
        dv_q_r[0][ri]   <= '0;
      end
      dv_den_r[0]  <= {mag, 1'b0};
      dv_gs_r[0]   <= sq_gs_r[SQRT_STAGES];
      dv_alb_r[0]  <= alb_nxt;
      dv_dark_r[0] <= dark_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // divide stages: one quotient bit per stage in each of three lanes
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    localparam int unsigned B = DIV_STAGES - 1 - i;
    logic [NUM_W-1:0] dshift;
    assign dshift = NUM_W'(dv_den_r[i]) << B;
    for (genvar ri = 0; ri < 3; ri++) begin : g_lane
      logic fits;
      assign fits = dv_rem_r[i][ri] >= dshift;
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem_r[i+1][ri] <= fits ? (dv_rem_r[i][ri] - dshift) : dv_rem_r[i][ri];
          dv_q_r[i+1][ri]   <= dv_q_r[i][ri] | (Q_W'(fits) << B);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_den_r[i+1]  <= dv_den_r[i];
        dv_gs_r[i+1]   <= dv_gs_r[i];
        dv_alb_r[i+1]  <= dv_alb_r[i];
        dv_dark_r[i+1] <= dv_dark_r[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register: clamp, sign, dark default
  // ---------------------------------------------------------------------------
  logic signed [NORM_W-1:0] nrm_nxt [0:2];
  logic signed [NORM_W-1:0] nrm_r   [0:2];
  logic [ALB_W-1:0]         alb_r;
  logic                     dark_r;

  for (genvar ri = 0; ri < 3; ri++) begin : g_fin
    logic [Q_W-1:0]    qc;
    logic [NORM_W-1:0] mag16;
    assign qc    = (dv_q_r[DIV_STAGES][ri] > ONE_Q14) ? ONE_Q14 : dv_q_r[DIV_STAGES][ri];
    assign mag16 = NORM_W'(qc);
    always_comb begin
      if (dv_dark_r[DIV_STAGES]) begin
        nrm_nxt[ri] = (ri == 2) ? $signed(NORM_W'(ONE_Q14)) : '0;
      end else if (dv_gs_r[DIV_STAGES][ri]) begin
        nrm_nxt[ri] = $signed(~mag16 + NORM_W'(1));
      end else begin
        nrm_nxt[ri] = $signed(mag16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ri = 0; ri < 3; ri++) begin
        nrm_r[ri] <= nrm_nxt[ri];
      end
      alb_r  <= dv_dark_r[DIV_STAGES] ? '0 : dv_alb_r[DIV_STAGES];
      dark_r <= dv_dark_r[DIV_STAGES];
    end
  end

  assign out_valid      = v_r[NST-1];
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_albedo     = alb_r;
  assign out_dark_pixel = dark_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `PSNA_ASSERT_IMP(a_dark_default, out_valid && out_dark_pixel, out_normal_x == '0 && out_normal_y == '0 && out_normal_z == $signed(NORM_W'(ONE_Q14)) && out_albedo == '0)
  `PSNA_ASSERT_IMP(a_lit_above_thr, out_valid && !out_dark_pixel, out_albedo >= thr_r)
  `PSNA_ASSERT_IMP(a_norm_range, out_valid, out_normal_x <= 16'sd16384 && out_normal_x >= -16'sd16384 && out_normal_y <= 16'sd16384 && out_normal_y >= -16'sd16384 && out_normal_z <= 16'sd16384 && out_normal_z >= -16'sd16384)
  `PSNA_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, v_r[0])

endmodule
`default_nettype wire

[dv/tb_top.sv]
// testbench for the photometric stereo normal and albedo block
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import psna_pkg::*;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic [ALB_W-1:0]         albedo;
    logic                     dark;
  } pixel_result_t;

  // scoreboard: holds its own copy of the configuration and predicts each pixel
  class normal_scoreboard;
    logic [NL_W-1:0]    lights;
    logic [COEFS_W-1:0] coefs[NUM_OBS];
    logic [ALB_W-1:0]   thresh;
    pixel_result_t      pending[$];
    int                 errors;
    int                 checked;
    int                 dark_seen;

    function void reset_cfg();
      lights = NL_RESET;
      foreach (coefs[i]) coefs[i] = '0;
      thresh = THR_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEFS_W-1:0] val);
      if (idx == CFG_NUM_LIGHTS) lights = val[NL_W-1:0];
      else if (idx == CFG_THRESHOLD) thresh = val[ALB_W-1:0];
      else coefs[idx - CFG_LIGHT0] = val;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_pixel(logic [OBS_W-1:0] obs[NUM_OBS]);
      int               k;
      longint           acc[3], g[3], t, comp;
      longint unsigned  s, alb, mag, a, q;
      logic signed [COEF_W-1:0] c;
      pixel_result_t    res;
      k = (lights == NL_SIX) ? 6 : 4;
      acc = '{0, 0, 0};
      for (int i = 0; i < k; i++)
        for (int r = 0; r < 3; r++) begin
          c = coefs[i][r*COEF_W +: COEF_W];
          acc[r] += longint'(obs[i]) * longint'(c);
        end
      s = 0;
      for (int r = 0; r < 3; r++) begin
        // round half up from q.24 to q.16
        t = acc[r] + 128;
        g[r] = t >>> 8;
        a = (g[r] < 0) ? -g[r] : g[r];
        s += a * a;
      end
      alb = int_sqrt(s >> 16);
      if (alb > 64'hFFFFFF) alb = 64'hFFFFFF;
      if (s == 0 || alb < thresh) begin
        res = '{nx: 0, ny: 0, nz: 16384, albedo: 0, dark: 1'b1};
      end else begin
        mag = int_sqrt(s);
        for (int r = 0; r < 3; r++) begin
          a = (g[r] < 0) ? -g[r] : g[r];
          q = (a * 32768 + mag) / (2 * mag);
          if (q > 16384) q = 16384;
          comp = (g[r] < 0) ? -longint'(q) : longint'(q);
          if (r == 0) res.nx = comp[15:0];
          else if (r == 1) res.ny = comp[15:0];
          else res.nz = comp[15:0];
        end
        res.albedo = alb[ALB_W-1:0];
        res.dark = 1'b0;
      end
      pending.push_back(res);
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.dark) dark_seen++;
      if (got.nx !== exp_r.nx) begin
        $error("normal_x exp %0d got %0d", exp_r.nx, got.nx); errors++;
      end
      if (got.ny !== exp_r.ny) begin
        $error("normal_y exp %0d got %0d", exp_r.ny, got.ny); errors++;
      end
      if (got.nz !== exp_r.nz) begin
        $error("normal_z exp %0d got %0d", exp_r.nz, got.nz); errors++;
      end
      if (got.albedo !== exp_r.albedo) begin
        $error("albedo exp %0d got %0d", exp_r.albedo, got.albedo); errors++;
      end
      if (got.dark !== exp_r.dark) begin
        $error("dark_pixel exp %0d got %0d", exp_r.dark, got.dark); errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 52;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEFS_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OBS_W-1:0] in_obs[NUM_OBS];
  logic out_valid;
  logic out_stall = 1'b0;
  pixel_result_t out_r;

  // knobs for the two sides
  bit sender_quiet = 1'b0;   // no idling on the input side
  bit receiver_quiet = 1'b0; // no stalls on the output side
  bit hold_off = 1'b0;       // long receiver stall requested
  longint cycles = 0;

  normal_scoreboard sb;

  always #1 clk = ~clk;

  initial foreach (in_obs[i]) in_obs[i] = '0;

  photometric_stereo_normal_albedo dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_obs_0(in_obs[0]), .in_obs_1(in_obs[1]), .in_obs_2(in_obs[2]),
    .in_obs_3(in_obs[3]), .in_obs_4(in_obs[4]), .in_obs_5(in_obs[5]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_r.nx), .out_normal_y(out_r.ny), .out_normal_z(out_r.nz),
    .out_albedo(out_r.albedo), .out_dark_pixel(out_r.dark)
  );

  // watchdog on total cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // sample accepted results at the rising edge
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_r);

  // receiver stall, changed on the falling edge
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (receiver_quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 11);
  end

  // long receiver hold-off counted in its own process
  task automatic receiver_hold(int n);
    hold_off = 1'b1;
    repeat (n) @(negedge clk);
    hold_off = 1'b0;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [COEFS_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until the pipe has drained, then settle
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // offer one pixel and hold it until it is transferred
  task automatic send_pixel(logic [OBS_W-1:0] obs[NUM_OBS]);
    while (!sender_quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    foreach (obs[i]) in_obs[i] <= obs[i];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(obs);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(5))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return '0;
      3: return COEF_W'($urandom_range(20'h3FFF) - 20'h2000);
      default: return COEF_W'($urandom());
    endcase
  endfunction

  // random matrix; small coefficients now and then so that some pixels go dark
  task automatic random_matrix();
    logic [COEFS_W-1:0] v;
    for (int i = 0; i < NUM_OBS; i++) begin
      v = {rand_coef(), rand_coef(), rand_coef()};
      write_cfg(CFG_IDX_W'(CFG_LIGHT0 + i), v);
    end
  endtask

  task automatic random_pixels(int n, int max_obs);
    logic [OBS_W-1:0] obs[NUM_OBS];
    for (int j = 0; j < n; j++) begin
      foreach (obs[i])
        obs[i] = ($urandom_range(9) == 0) ? OBS_W'($urandom)
                                          : OBS_W'($urandom_range(max_obs));
      send_pixel(obs);
    end
  endtask

  initial begin
    logic [OBS_W-1:0] obs[NUM_OBS];
    logic [NL_W-1:0] nl_vals[4];
    logic [ALB_W-1:0] thr_vals[5];
    sb = new();
    sb.reset_cfg();
    nl_vals = '{3'd6, 3'd4, 3'd7, 3'd0};
    thr_vals = '{24'd0, 24'hFFFFFF, 24'd1, 24'd300, 24'd20000};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset config gives zero g, so every pixel is dark
    sender_quiet = 1'b1;
    foreach (obs[i]) obs[i] = 16'hFFFF;
    send_pixel(obs);
    stop_sending();
    drain();

    // directed: extreme coefficients, both light counts, zero and full intensity
    write_cfg(CFG_THRESHOLD, COEFS_W'(24'd0));
    for (int i = 0; i < NUM_OBS; i++)
      write_cfg(CFG_IDX_W'(CFG_LIGHT0 + i),
                (i % 2) ? {20'h80000, 20'h80000, 20'h80000}
                        : {20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
    for (int m = 0; m < 2; m++) begin
      write_cfg(CFG_NUM_LIGHTS, COEFS_W'(m ? 3'd6 : 3'd4));
      foreach (obs[i]) obs[i] = 16'h0000;
      send_pixel(obs);  // zero magnitude, dark with threshold zero
      foreach (obs[i]) obs[i] = 16'hFFFF;
      send_pixel(obs);
      foreach (obs[i]) obs[i] = (i % 2) ? 16'h0000 : 16'hFFFF;
      send_pixel(obs);
      foreach (obs[i]) obs[i] = (i % 2) ? 16'hFFFF : 16'h0000;
      send_pixel(obs);
      foreach (obs[i]) obs[i] = 16'h0001 << i;
      send_pixel(obs);
      stop_sending();
      drain();
    end
    // a single axis gives exact unit normals of either sign
    write_cfg(CFG_LIGHT0, {20'h10000, 20'h0, 20'h0});
    write_cfg(CFG_LIGHT1, {20'h0, 20'hF0000, 20'h0});
    write_cfg(CFG_NUM_LIGHTS, COEFS_W'(3'd4));
    for (int i = 0; i < 4; i++) begin
      foreach (obs[j]) obs[j] = '0;
      obs[i % 2] = 16'h0100 << i;
      send_pixel(obs);
    end
    stop_sending();
    drain();

    // random phases across light counts and thresholds
    sender_quiet = 1'b0;
    for (int p = 0; p < 10; p++) begin
      write_cfg(CFG_NUM_LIGHTS, COEFS_W'(nl_vals[p % 4]));
      write_cfg(CFG_THRESHOLD, COEFS_W'(thr_vals[p % 5]));
      random_matrix();
      sender_quiet = (p == 3);
      receiver_quiet = (p == 3);
      if (p == 5) begin
        // the receiver holds off while the sender keeps offering
        fork
          receiver_hold(200);
          random_pixels(130, (p % 2) ? 16'hFFFF : 16'h0FFF);
        join
      end else begin
        random_pixels(130, (p % 2) ? 16'hFFFF : 16'h0FFF);
      end
      // sender pauses until every expected result has come
      stop_sending();
      drain();
    end
    receiver_quiet = 1'b0;

    $display("checked %0d pixels, %0d dark, over several light counts and thresholds",
             sb.checked, sb.dark_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
